FILE: src/nalscan_pkg.sv
`timescale 1ns / 1ps

package nalscan_pkg;

	// start code bytes
	localparam logic [7:0] SC_ZERO_BYTE = 8'h00;
	localparam logic [7:0] SC_ONE_BYTE  = 8'h01;

	// nal unit types that carry the three-byte svc extension
	localparam logic [4:0] NAL_TYPE_PREFIX    = 5'd14;
	localparam logic [4:0] NAL_TYPE_SLICE_EXT = 5'd20;

	// width of the offset and length fields of a record
	localparam int unsigned REC_WIDTH = 32;

	typedef struct packed {
		logic [7:0] stream_byte;
	} scan_in_t;

	typedef struct packed {
		logic [4:0]           unit_type;
		logic [REC_WIDTH-1:0] unit_offset;
		logic [REC_WIDTH-1:0] unit_length;
		logic                 has_svc_ext;
		logic                 idr_pic;
		logic [2:0]           dep_id;
		logic [3:0]           qual_id;
		logic [2:0]           temp_id;
	} scan_rec_t;

	// svc extension ids of the unit under scan
	typedef struct packed {
		logic       idr_pic;
		logic [2:0] dep_id;
		logic [3:0] qual_id;
		logic [2:0] temp_id;
	} svc_ids_t;

	function automatic logic is_svc_type(input logic [4:0] t);
		is_svc_type = (t == NAL_TYPE_PREFIX) || (t == NAL_TYPE_SLICE_EXT);
	endfunction

endpackage

FILE: src/nalscan_in_if.sv
`timescale 1ns / 1ps

interface nalscan_in_if
	import nalscan_pkg::*;
();
	logic     valid;
	logic     ready;
	scan_in_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: src/nalscan_out_if.sv
`timescale 1ns / 1ps

interface nalscan_out_if
	import nalscan_pkg::*;
();
	logic      valid;
	logic      ready;
	scan_rec_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: src/svc_nal_unit_scanner_top.sv
`timescale 1ns / 1ps

// a record appears in the cycle after the item with the 01 of the next start code is taken
// throughput: one byte item per cycle; the per-byte phase logic and offset subtract set it
// the input stalls only while a finished record waits in the output register
// reset: arst_n clears phase, byte position, open-unit state and the output valid flag
// no record is given for bytes before the first start code or for the final open unit
module svc_nal_unit_scanner_top
	import nalscan_pkg::*;
#(
	parameter int unsigned OFFSET_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	nalscan_in_if.sink    in_ch,
	nalscan_out_if.source out_ch
);

	// scan phases
	localparam logic [2:0] PH_ZERO0 = 3'd0;
	localparam logic [2:0] PH_ZERO1 = 3'd1;
	localparam logic [2:0] PH_ZERO2 = 3'd2;
	localparam logic [2:0] PH_WAIT1 = 3'd3;
	localparam logic [2:0] PH_HDR   = 3'd4;
	localparam logic [2:0] PH_EXT0  = 3'd5;
	localparam logic [2:0] PH_EXT1  = 3'd6;
	localparam logic [2:0] PH_EXT2  = 3'd7;

	localparam logic [OFFSET_BITS-1:0] SC_BACK = OFFSET_BITS'(3);

	logic [2:0]             phase_q, phase_d;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] open_off_q, open_off_d;
	logic                   open_q, open_d;
	logic [4:0]             type_q, type_d;
	svc_ids_t               ids_q, ids_d;
	logic                   out_valid_q;
	scan_rec_t              rec_q;

	logic                   in_acc;
	logic [7:0]             b;
	logic                   emit;
	logic [OFFSET_BITS-1:0] start_pos;
	logic [OFFSET_BITS-1:0] len_full;
	logic [OFFSET_BITS+REC_WIDTH-1:0] off_ext, len_ext;
	logic                   ext;
	scan_rec_t              rec_d;

	// output register frees as soon as its record is taken
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign b           = in_ch.payload.stream_byte;

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = rec_q;

	// start code position and length of the closing unit
	assign start_pos = pos_q - SC_BACK;
	assign len_full  = start_pos - open_off_q;
	assign off_ext   = {{REC_WIDTH{1'b0}}, open_off_q};
	assign len_ext   = {{REC_WIDTH{1'b0}}, len_full};
	assign ext       = is_svc_type(type_q);

	// phase walk for one byte
	always_comb begin
		phase_d    = phase_q;
		open_off_d = open_off_q;
		open_d     = open_q;
		type_d     = type_q;
		ids_d      = ids_q;
		emit       = 1'b0;
		unique case (phase_q)
			PH_ZERO0, PH_ZERO1, PH_ZERO2: begin
				phase_d = (b == SC_ZERO_BYTE) ? phase_q + 3'd1 : PH_ZERO0;
			end
			PH_WAIT1: begin
				if (b == SC_ONE_BYTE) begin
					emit       = open_q;
					open_d     = 1'b1;
					open_off_d = start_pos;
					type_d     = '0;
					ids_d      = '0;
					phase_d    = PH_HDR;
				end else if (b != SC_ZERO_BYTE) begin
					phase_d = PH_ZERO0;
				end
			end
			PH_HDR: begin
				type_d  = b[4:0];
				phase_d = is_svc_type(b[4:0]) ? PH_EXT0 : PH_ZERO0;
			end
			PH_EXT0: begin
				ids_d.idr_pic = b[6];
				phase_d       = PH_EXT1;
			end
			PH_EXT1: begin
				ids_d.dep_id  = b[6:4];
				ids_d.qual_id = b[3:0];
				phase_d       = PH_EXT2;
			end
			PH_EXT2: begin
				ids_d.temp_id = b[7:5];
				phase_d       = PH_ZERO0;
			end
		endcase
	end

	// record of the unit that closes
	always_comb begin
		rec_d.unit_type   = type_q;
		rec_d.unit_offset = off_ext[REC_WIDTH-1:0];
		rec_d.unit_length = len_ext[REC_WIDTH-1:0];
		rec_d.has_svc_ext = ext;
		rec_d.idr_pic     = ext ? ids_q.idr_pic : 1'b0;
		rec_d.dep_id      = ext ? ids_q.dep_id : 3'd0;
		rec_d.qual_id     = ext ? ids_q.qual_id : 4'd0;
		rec_d.temp_id     = ext ? ids_q.temp_id : 3'd0;
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_ZERO0;
			pos_q      <= '0;
			open_off_q <= '0;
			open_q     <= 1'b0;
			type_q     <= '0;
			ids_q      <= '0;
		end else if (in_acc) begin
			phase_q    <= phase_d;
			pos_q      <= pos_q + 1'b1;
			open_off_q <= open_off_d;
			open_q     <= open_d;
			type_q     <= type_d;
			ids_q      <= ids_d;
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= emit;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output record
	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			rec_q <= rec_d;
		end
	end

`ifndef NO_ASSERTIONS
	// header phase is entered only from the wait for 01
	a_hdr_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HDR && $past(phase_q) != PH_HDR) |-> $past(phase_q) == PH_WAIT1)
		else $error("header phase entered without a start code");

	// a new record only follows an accepted item
	a_rec_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_acc))
		else $error("record appeared without an accepted item");

	// once a unit is open it stays open
	a_open_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |=> open_q)
		else $error("open unit flag dropped");

	// extension flag matches the unit type
	a_ext_type: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rec_q.has_svc_ext) |->
		(rec_q.unit_type == NAL_TYPE_PREFIX || rec_q.unit_type == NAL_TYPE_SLICE_EXT))
		else $error("extension flag on a plain unit");

	// plain units carry zero ids
	a_plain_ids: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rec_q.has_svc_ext) |->
		(!rec_q.idr_pic && rec_q.dep_id == 3'd0 && rec_q.qual_id == 4'd0
			&& rec_q.temp_id == 3'd0))
		else $error("plain unit with nonzero ids");
`endif

endmodule

FILE: tb/svc_nal_unit_scanner_top_tb.sv
`timescale 1ns / 1ps

module svc_nal_unit_scanner_top_tb;
	import nalscan_pkg::*;

	localparam int unsigned OFFSET_BITS  = 32;
	localparam int unsigned RANDOM_ITEMS = 420;
	localparam int unsigned HOLD_CYCLES  = 60;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned IDLE_PCT     = 26;
	localparam int unsigned MAX_REPORTS  = 10;
	localparam int unsigned CALM_FIRST   = 200;
	localparam int unsigned CALM_LAST    = 300;
	localparam int unsigned HOLD_AT      = 80;

	// scan phases of the start code search
	typedef enum logic [2:0] {
		HUNT0, HUNT1, HUNT2, HUNT_ONE, HDR, EXT0, EXT1, EXT2
	} scan_phase_e;

	// record written into the table for a byte, or none
	typedef struct packed {
		logic      pinned;
		logic      has_rec;
		scan_rec_t rec;
	} pin_t;

	typedef struct packed {
		logic [7:0] b;
		pin_t       exp;
	} dir_row_t;

	localparam scan_rec_t NO_REC     = '0;
	localparam pin_t      NOT_PINNED = '0;
	localparam int unsigned DIR_COUNT = 28;

	// leading byte, svc unit with long zero run, hidden zeros in extension, plain unit
	localparam dir_row_t DIRECTED [0:DIR_COUNT-1] = '{
		'{8'hFF, '{1'b1, 1'b0, NO_REC}},
		'{8'h00, NOT_PINNED},
		'{8'h00, NOT_PINNED},
		'{8'h00, NOT_PINNED},
		'{8'h01, '{1'b1, 1'b0, NO_REC}},
		'{8'h6E, NOT_PINNED},
		'{8'hFF, NOT_PINNED},
		'{8'hFF, NOT_PINNED},
		'{8'hFF, NOT_PINNED},
		'{8'h00, NOT_PINNED},
		'{8'h00, NOT_PINNED},
		'{8'h00, NOT_PINNED},
		'{8'h00, NOT_PINNED},
		'{8'h01, '{1'b1, 1'b1,
			{5'd14, 32'd1, 32'd9, 1'b1, 1'b1, 3'd7, 4'd15, 3'd7}}},
		'{8'h14, NOT_PINNED},
		'{8'h00, NOT_PINNED},
		'{8'h00, NOT_PINNED},
		'{8'h00, NOT_PINNED},
		'{8'h01, NOT_PINNED},
		'{8'h00, NOT_PINNED},
		'{8'h00, NOT_PINNED},
		'{8'h00, NOT_PINNED},
		'{8'h01, '{1'b1, 1'b1,
			{5'd20, 32'd10, 32'd9, 1'b1, 1'b0, 3'd0, 4'd0, 3'd0}}},
		'{8'hFF, NOT_PINNED},
		'{8'h00, NOT_PINNED},
		'{8'h00, NOT_PINNED},
		'{8'h00, NOT_PINNED},
		'{8'h01, '{1'b1, 1'b1,
			{5'd31, 32'd19, 32'd5, 1'b0, 1'b0, 3'd0, 4'd0, 3'd0}}}
	};

	logic clk;
	logic arst_n;

	nalscan_in_if  in_ch ();
	nalscan_out_if out_ch ();

	svc_nal_unit_scanner_top #(
		.OFFSET_BITS(OFFSET_BITS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// scanner state mirror
	scan_phase_e            m_phase;
	logic [OFFSET_BITS-1:0] m_pos;
	logic [OFFSET_BITS-1:0] m_offset;
	logic                   m_open;
	logic [4:0]             m_type;
	svc_ids_t               m_ids;

	pin_t      pinned_q [$];
	scan_rec_t unit_q [$];

	int unsigned bytes_sent;
	int unsigned bytes_taken;
	int unsigned recs_predicted;
	int unsigned recs_checked;
	int unsigned svc_checked;
	int unsigned mismatches;
	int unsigned hold_left;
	logic        hold_done;
	logic        calm;

	logic      mon_got;
	scan_rec_t mon_rec;
	pin_t      mon_pin;
	scan_rec_t mon_want;

	assign calm = (bytes_taken >= CALM_FIRST) && (bytes_taken < CALM_LAST);

	// step the scanner mirror by one byte
	task automatic scan_byte(input logic [7:0] b, output logic got, output scan_rec_t rec);
		logic [OFFSET_BITS-1:0] start;
		logic                   ext;
		got = 1'b0;
		rec = '0;
		case (m_phase)
			HUNT0: m_phase = (b == SC_ZERO_BYTE) ? HUNT1 : HUNT0;
			HUNT1: m_phase = (b == SC_ZERO_BYTE) ? HUNT2 : HUNT0;
			HUNT2: m_phase = (b == SC_ZERO_BYTE) ? HUNT_ONE : HUNT0;
			HUNT_ONE: begin
				if (b == SC_ONE_BYTE) begin
					// start code is the last three zeros and the 01
					start = m_pos - 3;
					if (m_open) begin
						ext = (m_type == NAL_TYPE_PREFIX) || (m_type == NAL_TYPE_SLICE_EXT);
						got = 1'b1;
						rec.unit_type   = m_type;
						rec.unit_offset = m_offset[REC_WIDTH-1:0];
						rec.unit_length = (start - m_offset);
						rec.has_svc_ext = ext;
						if (ext) begin
							rec.idr_pic = m_ids.idr_pic;
							rec.dep_id  = m_ids.dep_id;
							rec.qual_id = m_ids.qual_id;
							rec.temp_id = m_ids.temp_id;
						end
					end
					m_open   = 1'b1;
					m_offset = start;
					m_type   = '0;
					m_ids    = '0;
					m_phase  = HDR;
				end else if (b != SC_ZERO_BYTE) begin
					m_phase = HUNT0;
				end
			end
			HDR: begin
				m_type  = b[4:0];
				m_phase = (m_type == NAL_TYPE_PREFIX || m_type == NAL_TYPE_SLICE_EXT) ?
					EXT0 : HUNT0;
			end
			EXT0: begin
				m_ids.idr_pic = b[6];
				m_phase = EXT1;
			end
			EXT1: begin
				m_ids.dep_id  = b[6:4];
				m_ids.qual_id = b[3:0];
				m_phase = EXT2;
			end
			default: begin
				m_ids.temp_id = b[7:5];
				m_phase = HUNT0;
			end
		endcase
		m_pos = m_pos + 1;
	endtask

	function automatic string rec_text(input scan_rec_t r);
		return $sformatf("type %0d off %0d len %0d ext %0b idr %0b did %0d qid %0d tid %0d",
			r.unit_type, r.unit_offset, r.unit_length, r.has_svc_ext, r.idr_pic,
			r.dep_id, r.qual_id, r.temp_id);
	endfunction

	task automatic flag_mismatch(input string why, input scan_rec_t want, input scan_rec_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%t: %s", $realtime, why);
			$display("  expected %s", rec_text(want));
			$display("  actual   %s", rec_text(got));
		end
	endtask

	// offer one byte item, with random idle cycles ahead of it, none while calm
	task automatic offer_byte(input logic [7:0] b, input pin_t exp);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pinned_q.insert(pinned_q.size(), exp);
		in_ch.valid <= 1'b1;
		in_ch.payload.stream_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
		bytes_sent++;
	endtask

	task automatic offer_body(input int unsigned len);
		repeat (len) begin
			if ($urandom_range(0, 99) < 20)
				offer_byte(SC_ZERO_BYTE, NOT_PINNED);
			else
				offer_byte(8'($urandom_range(0, 255)), NOT_PINNED);
		end
	endtask

	// one unit of stream: mostly well formed, some broken start codes and extensions
	task automatic send_random_unit();
		int unsigned pick;
		int unsigned ext_bytes;
		logic [4:0]  kind;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			// near miss: short zero run or random closing byte, which can still be 01
			repeat ($urandom_range(2, 3)) offer_byte(SC_ZERO_BYTE, NOT_PINNED);
			offer_byte(8'($urandom_range(1, 255)), NOT_PINNED);
			offer_body($urandom_range(0, 4));
		end else begin
			repeat (3 + ((pick < 25) ? $urandom_range(1, 3) : 0))
				offer_byte(SC_ZERO_BYTE, NOT_PINNED);
			offer_byte(SC_ONE_BYTE, NOT_PINNED);
			pick = $urandom_range(0, 99);
			kind = (pick < 40) ? NAL_TYPE_PREFIX :
				(pick < 70) ? NAL_TYPE_SLICE_EXT : 5'($urandom_range(0, 31));
			offer_byte({3'($urandom_range(0, 7)), kind}, NOT_PINNED);
			if (kind == NAL_TYPE_PREFIX || kind == NAL_TYPE_SLICE_EXT) begin
				ext_bytes = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 2) : 3;
				repeat (ext_bytes) offer_byte(8'($urandom_range(0, 255)), NOT_PINNED);
			end
			offer_body($urandom_range(0, 6));
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("svc_nal_unit_scanner_top verification failed");
		$finish;
	end

	// receiver ready, with one long hold while the sender keeps offering
	initial begin
		hold_left = 0;
		hold_done = 1'b0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (!hold_done && bytes_taken >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_ch.ready <= 1'b0;
			end else if (calm) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// predict on accepted bytes, check accepted records
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			if (unit_q.size() == 0) begin
				flag_mismatch("record with none expected", NO_REC, out_ch.payload);
			end else begin
				mon_want = unit_q.pop_front();
				recs_checked++;
				if (mon_want.has_svc_ext)
					svc_checked++;
				if (out_ch.payload.unit_type !== mon_want.unit_type ||
						out_ch.payload.unit_offset !== mon_want.unit_offset ||
						out_ch.payload.unit_length !== mon_want.unit_length ||
						out_ch.payload.has_svc_ext !== mon_want.has_svc_ext ||
						out_ch.payload.idr_pic !== mon_want.idr_pic ||
						out_ch.payload.dep_id !== mon_want.dep_id ||
						out_ch.payload.qual_id !== mon_want.qual_id ||
						out_ch.payload.temp_id !== mon_want.temp_id)
					flag_mismatch("record field mismatch", mon_want, out_ch.payload);
			end
		end
		if (in_ch.valid && in_ch.ready) begin
			bytes_taken++;
			scan_byte(in_ch.payload.stream_byte, mon_got, mon_rec);
			mon_pin = pinned_q.pop_front();
			if (mon_pin.pinned) begin
				mon_got = mon_pin.has_rec;
				mon_rec = mon_pin.rec;
			end
			if (mon_got) begin
				unit_q.insert(unit_q.size(), mon_rec);
				recs_predicted++;
			end
		end
	end

	// stimulus and end of run
	initial begin
		m_phase        = HUNT0;
		m_pos          = '0;
		m_offset       = '0;
		m_open         = 1'b0;
		m_type         = '0;
		m_ids          = '0;
		bytes_sent     = 0;
		bytes_taken    = 0;
		recs_predicted = 0;
		recs_checked   = 0;
		svc_checked    = 0;
		mismatches     = 0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.payload <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed stream
		for (int i = 0; i < DIR_COUNT; i++)
			offer_byte(DIRECTED[i].b, DIRECTED[i].exp);

		// random units
		while (bytes_sent < DIR_COUNT + RANDOM_ITEMS)
			send_random_unit();
		in_ch.valid <= 1'b0;

		while (unit_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		mismatches += unit_q.size();
		$display("scanned %0d stream bytes, checked %0d unit records (%0d with svc ids)",
			bytes_taken, recs_checked, svc_checked);
		$display("output held off for %0d cycles once, %0d mismatches", HOLD_CYCLES, mismatches);
		if (mismatches == 0)
			$display("svc_nal_unit_scanner_top verification clean");
		else
			$display("svc_nal_unit_scanner_top verification failed");
		$finish;
	end

endmodule
